@@ src/can_frame_change_monitor_top_macros.svh @@
// assertion macros for the can frame change monitor checker
// each macro checks on the rising edge of clk and is off while rst_n is low
`ifndef CAN_FRAME_CHANGE_MONITOR_TOP_MACROS_SVH
`define CAN_FRAME_CHANGE_MONITOR_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CFM_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("can frame change monitor check failed");

// consequent must hold in the cycle after the antecedent
`define CFM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("can frame change monitor check failed");

`endif

@@ src/cfm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_pkg
// Shared types and constants of the CAN frame change monitor.
// ----------------------------------------------------------------------------
package cfm_pkg;

    localparam int ID_W       = 11;
    localparam int LEN_W      = 4;
    localparam int PAY_W      = 64;
    localparam int CNT_W      = 32;
    localparam int THR_W      = 16;
    localparam int NOTICE_W   = 8;
    localparam int MODE_W     = 3;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BYTE_W     = 8;

    // per-ID flag word
    localparam int FLAG_W    = 3;
    localparam int FLAG_SEEN = 0;
    localparam int FLAG_MASK = 1;
    localparam int FLAG_BASE = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FRAME    = 2'd0,
        OP_MASK     = 2'd1,
        OP_BASELINE = 2'd2,
        OP_IGNORED  = 2'd3
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MD_MONITOR = 3'd0,
        MD_DELTA   = 3'd1,
        MD_DECODE  = 3'd2,
        MD_STATS   = 3'd3,
        MD_SILENT  = 3'd4,
        MD_HUNT    = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_LOG_ENABLE  = 3'd1,
        REG_FILTER_ON   = 3'd2,
        REG_FILTER_VAL  = 3'd3,
        REG_PAUSED      = 3'd4,
        REG_NOISE_ON    = 3'd5,
        REG_QUIET       = 3'd6,
        REG_THRESHOLD   = 3'd7
    } cfg_reg_t;

    localparam logic [MODE_W-1:0] MODE_RESET      = MD_DELTA;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [ID_W-1:0]  can_id;
        logic             is_remote;
        logic [LEN_W-1:0] length;
        logic [PAY_W-1:0] payload;
        logic             entry_enable;
    } req_t;

    typedef struct packed {
        logic                accepted;
        logic                to_log;
        logic                is_new;
        logic                differs;
        logic                report;
        logic                suppressed;
        logic [LEN_W-1:0]    old_length;
        logic [PAY_W-1:0]    old_payload;
        logic [PAY_W-1:0]    hunt_diff;
        logic [NOTICE_W-1:0] noisy_notice;
        logic [CNT_W-1:0]    frame_count;
    } rsp_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic calc;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

@@ src/cfm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/cfm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_ctrl
// Sequencer of the monitor: table clear after reset, then read, compute and
// write back of one item at a time.
// ----------------------------------------------------------------------------
module cfm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  cfm_pkg::ctrl_sts_t sts,
    output cfm_pkg::ctrl_cmd_t cmd
);

    import cfm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ src/cfm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_datapath
// Configuration registers, per-ID tables and the frame evaluation logic of
// the monitor, plus the result register.
// ----------------------------------------------------------------------------
module cfm_datapath #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int DATA_BYTES    = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfm_pkg::ctrl_cmd_t                 cmd,
    output cfm_pkg::ctrl_sts_t                 sts,
    input  cfm_pkg::req_t                      req_item,
    input  logic                               cfg_valid,
    input  logic [cfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output cfm_pkg::rsp_t                      rsp_item
);

    import cfm_pkg::*;

    localparam int IX_W   = $clog2(TABLE_ENTRIES);
    localparam int DW     = BYTE_W * DATA_BYTES;
    localparam int CROW_W = CNT_W * DATA_BYTES;
    localparam int ENT_W  = LEN_W + DW + CNT_W;
    localparam int RED_W  = ID_W + 8;

    // table index: id modulo table size by restoring compare and subtract
    function automatic logic [IX_W-1:0] table_index(input logic [ID_W-1:0] id);
        logic [RED_W-1:0] rem;
        logic [RED_W-1:0] step;
        rem = RED_W'(id);
        for (int k = 7; k >= 0; k--)
        begin
            step = RED_W'(TABLE_ENTRIES) << k;
            if (rem >= step)
            begin
                rem = rem - step;
            end
        end
        return rem[IX_W-1:0];
    endfunction

    // configuration registers
    logic [MODE_W-1:0] cfg_mode_reg;
    logic              cfg_log_enable_reg;
    logic              cfg_filter_on_reg;
    logic [ID_W-1:0]   cfg_filter_value_reg;
    logic              cfg_paused_reg;
    logic              cfg_noise_on_reg;
    logic              cfg_quiet_reg;
    logic [THR_W-1:0]  cfg_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode_reg         <= MODE_RESET;
            cfg_log_enable_reg   <= 1'b0;
            cfg_filter_on_reg    <= 1'b0;
            cfg_filter_value_reg <= '0;
            cfg_paused_reg       <= 1'b0;
            cfg_noise_on_reg     <= 1'b0;
            cfg_quiet_reg        <= 1'b0;
            cfg_threshold_reg    <= THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:       cfg_mode_reg         <= cfg_data[MODE_W-1:0];
                REG_LOG_ENABLE: cfg_log_enable_reg   <= cfg_data[0];
                REG_FILTER_ON:  cfg_filter_on_reg    <= cfg_data[0];
                REG_FILTER_VAL: cfg_filter_value_reg <= cfg_data[ID_W-1:0];
                REG_PAUSED:     cfg_paused_reg       <= cfg_data[0];
                REG_NOISE_ON:   cfg_noise_on_reg     <= cfg_data[0];
                REG_QUIET:      cfg_quiet_reg        <= cfg_data[0];
                REG_THRESHOLD:  cfg_threshold_reg    <= cfg_data[THR_W-1:0];
                default:        cfg_mode_reg         <= cfg_mode_reg;
            endcase
        end
    end

    // flag table clear sweep after reset
    logic [IX_W-1:0] clr_addr_reg;
    logic            clr_done;
    logic            rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign clr_done = (clr_addr_reg == IX_W'(TABLE_ENTRIES - 1));

    // captured item and its table index
    req_t            item_reg;
    logic [IX_W-1:0] ix_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_item;
            ix_reg   <= table_index(req_item.can_id);
        end
    end

    // write-back values computed in the calc step
    logic [FLAG_W-1:0] flags_wdata_reg, flags_wdata_next;
    logic [ENT_W-1:0]  ent_wdata_reg, ent_wdata_next;
    logic [CROW_W-1:0] cnt_wdata_reg, cnt_wdata_next;
    logic              flag_we_reg, flag_we_next;
    logic              ent_we_reg, ent_we_next;
    logic              mask_we_reg, mask_we_next;
    logic              base_we_reg, base_we_next;
    logic              cnt_we_reg, cnt_we_next;
    rsp_t              calc_rsp_reg, calc_rsp_next;

    // table memories
    logic [FLAG_W-1:0] flags_rd;
    logic [ENT_W-1:0]  ent_rd;
    logic [DW-1:0]     mask_rd;
    logic [DW-1:0]     base_rd;
    logic [CROW_W-1:0] cnt_rd;
    logic              flag_ram_we;
    logic [IX_W-1:0]   flag_ram_waddr;
    logic [FLAG_W-1:0] flag_ram_wdata;
    logic [DW-1:0]     data_w;

    assign data_w         = item_reg.payload[DW-1:0];
    assign flag_ram_we    = cmd.clear_step | (cmd.commit & flag_we_reg);
    assign flag_ram_waddr = cmd.clear_step ? clr_addr_reg : ix_reg;
    assign flag_ram_wdata = cmd.clear_step ? '0 : flags_wdata_reg;

    cfm_ram #(.WIDTH(FLAG_W), .DEPTH(TABLE_ENTRIES)) u_flag_ram (
        .clk   (clk),
        .we    (flag_ram_we),
        .waddr (flag_ram_waddr),
        .wdata (flag_ram_wdata),
        .raddr (ix_reg),
        .rdata (flags_rd)
    );

    cfm_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (cmd.commit & ent_we_reg),
        .waddr (ix_reg),
        .wdata (ent_wdata_reg),
        .raddr (ix_reg),
        .rdata (ent_rd)
    );

    cfm_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_mask_ram (
        .clk   (clk),
        .we    (cmd.commit & mask_we_reg),
        .waddr (ix_reg),
        .wdata (data_w),
        .raddr (ix_reg),
        .rdata (mask_rd)
    );

    cfm_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_base_ram (
        .clk   (clk),
        .we    (cmd.commit & base_we_reg),
        .waddr (ix_reg),
        .wdata (data_w),
        .raddr (ix_reg),
        .rdata (base_rd)
    );

    cfm_ram #(.WIDTH(CROW_W), .DEPTH(TABLE_ENTRIES)) u_count_ram (
        .clk   (clk),
        .we    (cmd.commit & cnt_we_reg),
        .waddr (ix_reg),
        .wdata (cnt_wdata_reg),
        .raddr (ix_reg),
        .rdata (cnt_rd)
    );

    // entry fields and byte lane mask
    logic [LEN_W-1:0] ent_len;
    logic [DW-1:0]    ent_bytes;
    logic [CNT_W-1:0] ent_cnt;
    logic             seen;
    logic [LEN_W-1:0] n_bytes;
    logic [DW-1:0]    bm;

    assign {ent_len, ent_bytes, ent_cnt} = ent_rd;
    assign seen    = flags_rd[FLAG_SEEN];
    assign n_bytes = (item_reg.length < LEN_W'(DATA_BYTES)) ? item_reg.length
                                                            : LEN_W'(DATA_BYTES);

    always_comb
    begin
        for (int b = 0; b < DATA_BYTES; b++)
        begin
            bm[b*BYTE_W +: BYTE_W] = (LEN_W'(b) < n_bytes) ? '1 : '0;
        end
    end

    // hunt byte compare and change counts, one lane per byte
    logic [CROW_W-1:0]   cnt_hunt;
    logic [DW-1:0]       hunt_diff;
    logic [NOTICE_W-1:0] hunt_notice;

    always_comb
    begin
        logic [BYTE_W-1:0] d;
        logic [CNT_W-1:0]  c;
        cnt_hunt    = cnt_rd;
        hunt_diff   = '0;
        hunt_notice = '0;
        for (int b = 0; b < DATA_BYTES; b++)
        begin
            d = base_rd[b*BYTE_W +: BYTE_W] ^ data_w[b*BYTE_W +: BYTE_W];
            c = cnt_rd[b*CNT_W +: CNT_W] + 1'b1;
            if ((LEN_W'(b) < n_bytes) && (d != '0))
            begin
                cnt_hunt[b*CNT_W +: CNT_W] = c;
                if (cfg_quiet_reg && (c > CNT_W'(cfg_threshold_reg)))
                begin
                    if (c == CNT_W'(cfg_threshold_reg) + 1'b1)
                    begin
                        hunt_notice[b] = 1'b1;
                    end
                end
                else
                begin
                    hunt_diff[b*BYTE_W +: BYTE_W] = d;
                end
            end
        end
    end

    // frame evaluation and table updates
    logic             accept_ok;
    logic [DW-1:0]    old_bytes;
    logic [LEN_W-1:0] old_len;
    logic [CNT_W-1:0] old_cnt;
    logic             changed;
    logic [DW-1:0]    new_bytes;
    logic             hide;

    assign accept_ok = !(cfg_filter_on_reg && (item_reg.can_id != cfg_filter_value_reg));
    assign old_bytes = seen ? ent_bytes : '0;
    assign old_len   = seen ? ent_len : '0;
    assign old_cnt   = seen ? ent_cnt : '0;
    assign changed   = seen && !item_reg.is_remote
                       && ((ent_len != item_reg.length) || (((ent_bytes ^ data_w) & bm) != '0));
    assign new_bytes = item_reg.is_remote ? old_bytes : ((old_bytes & ~bm) | (data_w & bm));
    assign hide      = cfg_noise_on_reg && flags_rd[FLAG_MASK]
                       && (((data_w ^ old_bytes) & ~mask_rd & bm) == '0);

    always_comb
    begin
        calc_rsp_next    = '0;
        flags_wdata_next = flags_rd;
        ent_wdata_next   = '0;
        cnt_wdata_next   = cnt_hunt;
        flag_we_next     = 1'b0;
        ent_we_next      = 1'b0;
        mask_we_next     = 1'b0;
        base_we_next     = 1'b0;
        cnt_we_next      = 1'b0;
        unique case (item_reg.operation)
            OP_MASK:
            begin
                flags_wdata_next[FLAG_MASK] = item_reg.entry_enable;
                flag_we_next                = 1'b1;
                mask_we_next                = 1'b1;
            end
            OP_BASELINE:
            begin
                flags_wdata_next[FLAG_BASE] = item_reg.entry_enable;
                flag_we_next                = 1'b1;
                base_we_next                = 1'b1;
                cnt_we_next                 = 1'b1;
                cnt_wdata_next              = '0;
            end
            OP_FRAME:
            begin
                if (accept_ok)
                begin
                    calc_rsp_next.accepted = 1'b1;
                    calc_rsp_next.to_log   = cfg_log_enable_reg;
                    if (!cfg_paused_reg)
                    begin
                        flags_wdata_next[FLAG_SEEN] = 1'b1;
                        flag_we_next                = 1'b1;
                        ent_we_next                 = 1'b1;
                        ent_wdata_next = {item_reg.length, new_bytes, old_cnt + 1'b1};
                        calc_rsp_next.is_new      = !seen;
                        calc_rsp_next.differs     = changed;
                        calc_rsp_next.old_length  = old_len;
                        calc_rsp_next.old_payload = PAY_W'(old_bytes);
                        calc_rsp_next.frame_count = old_cnt + 1'b1;
                        unique case (cfg_mode_reg)
                            MD_MONITOR:
                            begin
                                calc_rsp_next.report = 1'b1;
                            end
                            MD_DELTA, MD_DECODE:
                            begin
                                if (!seen)
                                begin
                                    calc_rsp_next.report = 1'b1;
                                end
                                else if (changed)
                                begin
                                    calc_rsp_next.suppressed = hide;
                                    calc_rsp_next.report     = !hide;
                                end
                            end
                            MD_HUNT:
                            begin
                                if (flags_rd[FLAG_BASE])
                                begin
                                    cnt_we_next                = 1'b1;
                                    calc_rsp_next.hunt_diff    = PAY_W'(hunt_diff);
                                    calc_rsp_next.noisy_notice = hunt_notice;
                                    calc_rsp_next.report       = (hunt_diff != '0);
                                end
                            end
                            default:
                            begin
                                calc_rsp_next.report = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                flag_we_next = 1'b0;
            end
        endcase
    end

    // calc step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_we_reg <= 1'b0;
            ent_we_reg  <= 1'b0;
            mask_we_reg <= 1'b0;
            base_we_reg <= 1'b0;
            cnt_we_reg  <= 1'b0;
        end
        else if (cmd.calc)
        begin
            flag_we_reg <= flag_we_next;
            ent_we_reg  <= ent_we_next;
            mask_we_reg <= mask_we_next;
            base_we_reg <= base_we_next;
            cnt_we_reg  <= cnt_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            flags_wdata_reg <= flags_wdata_next;
            ent_wdata_reg   <= ent_wdata_next;
            cnt_wdata_reg   <= cnt_wdata_next;
            calc_rsp_reg    <= calc_rsp_next;
        end
    end

    // result register
    logic rsp_valid_reg;
    rsp_t rsp_item_reg;

    assign rsp_free = !rsp_valid_reg || rsp_ready;

    // status back to the sequencer
    assign sts = '{clear_done: clr_done, out_free: rsp_free};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_item_reg <= calc_rsp_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

@@ src/can_frame_change_monitor_top.sv @@
`timescale 1ns / 1ps
// Flow: one item at a time; an accepted item is captured, its per-ID table
// entries are read, the result is computed, and the tables are written back
// through single-port-read RAMs as the result is made valid; write back waits
// while the result is not taken. Reset: after rst_n is released the flag table
// is swept clean, one entry a cycle, with req_ready low; config writes are taken.
// ----------------------------------------------------------------------------
// can_frame_change_monitor_top
// Per-ID CAN frame tracker reporting new, changed and hunted frames.
// ----------------------------------------------------------------------------
module can_frame_change_monitor_top #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int DATA_BYTES    = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  cfm_pkg::req_t                  req_item,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output cfm_pkg::rsp_t                  rsp_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfm_pkg::CFG_DATA_W-1:0] cfg_data
);

    import cfm_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    cfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // tables and evaluation
    cfm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .DATA_BYTES    (DATA_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_item  (req_item),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

@@ src/cfm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_checker
// Port level checks of the CAN frame change monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "can_frame_change_monitor_top_macros.svh"

module cfm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input cfm_pkg::rsp_t rsp_item
);

    import cfm_pkg::*;

    logic reject_clean;
    logic new_clean;

    // field combinations expected of rejected and of new frames
    assign reject_clean = !rsp_item.to_log && !rsp_item.report && !rsp_item.is_new
                          && (rsp_item.frame_count == '0);
    assign new_clean    = (rsp_item.old_length == '0) && (rsp_item.old_payload == '0)
                          && (rsp_item.frame_count == CNT_W'(1)) && !rsp_item.differs;

    // one item at a time: busy right after an item is taken
    `CFM_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // a stalled result holds
    `CFM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

    // a rejected item shows nothing else
    `CFM_ASSERT_SAME(a_reject_empty, rsp_valid && !rsp_item.accepted, reject_clean)

    // a hidden change is a change and is not reported
    `CFM_ASSERT_SAME(a_suppress, rsp_valid && rsp_item.suppressed, rsp_item.differs && !rsp_item.report)

    // a new id starts from an empty entry
    `CFM_ASSERT_SAME(a_new_entry, rsp_valid && rsp_item.is_new, new_clean)

endmodule

bind can_frame_change_monitor_top cfm_checker u_cfm_checker (.*);
